[design/wrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants of the weighted random select tree
// Field widths, parameter defaults, request action codes and sequencer states.
// ----------------------------------------------------------------------------
package wrs_pkg;

   localparam int TREE_LEAVES_DEF = 1024;
   localparam int WEIGHT_BITS_DEF = 32;
   localparam int DRAW_BITS_DEF   = 32;

   localparam int ACTION_W   = 2;
   localparam int SLOT_W     = 10;
   localparam int WEIGHT_W   = 32;
   localparam int TARGET_W   = 42;
   localparam int DRAW_W     = 32;
   localparam int SUM_OUT_W  = 42;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 96;

   typedef enum logic [1:0] {
      ACT_SET    = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_PREFIX = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DN_RD,
      ST_DN_STEP,
      ST_LEAF_RD,
      ST_LEAF_WR,
      ST_UP_RD,
      ST_UP_WR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[design/wrs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[design/weighted_random_select_tree_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_random_select_tree_unit: weighted random selection over a sum tree
// Set weights, query prefix sums, search by threshold and draw weighted samples.
// ----------------------------------------------------------------------------
// Each tree node in one RAM holds the weight sum and the non-zero slot count of
// its subtree. Requests run one at a time under a small sequencer that reuses
// one adder; every tree level costs a RAM read state and a compute state. A
// sample first scales its draw by the total with shift-add steps; an
// out-of-range set or prefix, or a sample with zero total, goes straight to the
// done state. After reset a clearing pass zeroes the tree RAM before the first
// request is taken. A finished response waits in an output register while the
// next request is accepted.
module weighted_random_select_tree_unit #(
   parameter int TREE_LEAVES = wrs_pkg::TREE_LEAVES_DEF,
   parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF,
   parameter int DRAW_BITS   = wrs_pkg::DRAW_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // slot, weight, target, draw
   input  wire logic [wrs_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  wire logic [wrs_pkg::ACTION_W-1:0]   req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // chosen_slot, prefix_sum, total_weight
   output logic      [wrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found
   output logic      [0:0]                     rsp_tuser
);

   localparam int LEAF_W = $clog2(TREE_LEAVES);
   localparam int ADDR_W = LEAF_W + 1;
   localparam int SUM_W  = WEIGHT_BITS + LEAF_W;
   localparam int CNT_W  = LEAF_W + 1;
   localparam int NODE_W = SUM_W + CNT_W;
   localparam int CMP_W  = (SUM_W > wrs_pkg::TARGET_W ? SUM_W : wrs_pkg::TARGET_W) + 1;
   localparam int MCNT_W = $clog2(DRAW_BITS + 1);

   wrs_pkg::state_type  state_ff, state_in;
   wrs_pkg::action_type action_ff, action_in;
   logic [ADDR_W-1:0]  node_ff, node_in;
   logic [LEAF_W-1:0]  path_ff, path_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [CMP_W-1:0]   target_ff, target_in;
   logic [SUM_W-1:0]   new_w_ff, new_w_in;
   logic [SUM_W-1:0]   delta_ff, delta_in;
   logic [CNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [DRAW_BITS-1:0] draw_ff, draw_in;
   logic [MCNT_W-1:0]  mcnt_ff, mcnt_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   nz_ff, nz_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               found_ff, found_in;
   logic [LEAF_W-1:0]  chosen_ff, chosen_in;
   logic [SUM_W-1:0]   psum_ff, psum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [wrs_pkg::SLOT_W-1:0]    rsp_chosen_ff, rsp_chosen_in;
   logic [wrs_pkg::SUM_OUT_W-1:0] rsp_psum_ff, rsp_psum_in;
   logic [wrs_pkg::SUM_OUT_W-1:0] rsp_total_ff, rsp_total_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [NODE_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [NODE_W-1:0] ram_rdata;
   logic [SUM_W-1:0]  rd_sum;
   logic [CNT_W-1:0]  rd_cnt;

   logic [SUM_W:0]    alu_a, alu_b, alu_sum;
   logic              alu_cin;

   logic               req_fire, rsp_free, slot_ok, left_ok, go_right;
   logic [ADDR_W-1:0]  node_step;
   logic [wrs_pkg::SLOT_W-1:0] req_slot;
   logic [CNT_W-1:0]   up_cnt;

   wrs_ram #(
      .WIDTH (NODE_W),
      .DEPTH (2 * TREE_LEAVES)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_sum   = ram_rdata[NODE_W-1:CNT_W];
   assign rd_cnt   = ram_rdata[CNT_W-1:0];
   assign req_slot = req_tdata[9:0];
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign slot_ok  = 32'(req_slot) < 32'(TREE_LEAVES - 1);
   assign alu_sum  = alu_a + alu_b + (SUM_W + 1)'(alu_cin);
   assign left_ok  = (rd_cnt != '0) && (CMP_W'(alu_sum[SUM_W-1:0]) >= target_ff);
   assign go_right = (action_ff == wrs_pkg::ACT_PREFIX) ? path_ff[LEAF_W-1] : !left_ok;
   assign node_step = {node_ff[ADDR_W-2:0], go_right};
   assign up_cnt   = rd_cnt + dcnt_ff;

   assign req_tready = (state_ff == wrs_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_psum_ff, rsp_chosen_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrs_pkg::ST_CLEAR: begin
            if (clr_ff == {ADDR_W{1'b1}}) state_in = wrs_pkg::ST_IDLE;
         end
         wrs_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (wrs_pkg::action_type'(req_tuser))
                  wrs_pkg::ACT_SET:
                     state_in = slot_ok ? wrs_pkg::ST_LEAF_RD : wrs_pkg::ST_DONE;
                  wrs_pkg::ACT_SEARCH:
                     state_in = wrs_pkg::ST_CHECK;
                  wrs_pkg::ACT_SAMPLE:
                     state_in = (total_ff == '0) ? wrs_pkg::ST_DONE : wrs_pkg::ST_MUL;
                  default:
                     state_in = slot_ok ? wrs_pkg::ST_DN_RD : wrs_pkg::ST_DONE;
               endcase
            end
         end
         wrs_pkg::ST_MUL: begin
            if (mcnt_ff == MCNT_W'(DRAW_BITS - 1)) state_in = wrs_pkg::ST_CHECK;
         end
         wrs_pkg::ST_CHECK: begin
            if (nz_ff == '0 || CMP_W'(total_ff) < target_ff) state_in = wrs_pkg::ST_DONE;
            else state_in = wrs_pkg::ST_DN_RD;
         end
         wrs_pkg::ST_DN_RD:   state_in = wrs_pkg::ST_DN_STEP;
         wrs_pkg::ST_DN_STEP: begin
            state_in = node_step[ADDR_W-1] ? wrs_pkg::ST_DONE : wrs_pkg::ST_DN_RD;
         end
         wrs_pkg::ST_LEAF_RD: state_in = wrs_pkg::ST_LEAF_WR;
         wrs_pkg::ST_LEAF_WR: state_in = wrs_pkg::ST_UP_RD;
         wrs_pkg::ST_UP_RD:   state_in = wrs_pkg::ST_UP_WR;
         wrs_pkg::ST_UP_WR: begin
            state_in = (node_ff == ADDR_W'(1)) ? wrs_pkg::ST_DONE : wrs_pkg::ST_UP_RD;
         end
         wrs_pkg::ST_DONE: begin
            if (rsp_free) state_in = wrs_pkg::ST_IDLE;
         end
         default: state_in = wrs_pkg::ST_IDLE;
      endcase
   end

   // RAM port and shared adder
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = {alu_sum[SUM_W-1:0], up_cnt};
      ram_raddr = node_ff;
      alu_a     = {1'b0, acc_ff};
      alu_b     = {1'b0, rd_sum};
      alu_cin   = 1'b0;
      unique case (state_ff)
         wrs_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         wrs_pkg::ST_MUL: begin
            alu_b = draw_ff[0] ? {1'b0, total_ff} : '0;
         end
         wrs_pkg::ST_DN_RD: begin
            ram_raddr = {node_ff[ADDR_W-2:0], 1'b0};
         end
         wrs_pkg::ST_LEAF_WR: begin
            ram_we    = 1'b1;
            ram_wdata = {new_w_ff, CNT_W'(new_w_ff != '0)};
            alu_a     = {1'b0, new_w_ff};
            alu_b     = {1'b0, ~rd_sum};
            alu_cin   = 1'b1;
         end
         wrs_pkg::ST_UP_WR: begin
            ram_we = 1'b1;
            alu_a  = {1'b0, rd_sum};
            alu_b  = {1'b0, delta_ff};
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      action_in     = action_ff;
      node_in       = node_ff;
      path_in       = path_ff;
      acc_in        = acc_ff;
      target_in     = target_ff;
      new_w_in      = new_w_ff;
      delta_in      = delta_ff;
      dcnt_in       = dcnt_ff;
      draw_in       = draw_ff;
      mcnt_in       = mcnt_ff;
      total_in      = total_ff;
      nz_in         = nz_ff;
      clr_in        = clr_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      psum_in       = psum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_psum_in   = rsp_psum_ff;
      rsp_total_in  = rsp_total_ff;
      unique case (state_ff)
         wrs_pkg::ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
         end
         wrs_pkg::ST_IDLE: begin
            if (req_fire) begin
               action_in = wrs_pkg::action_type'(req_tuser);
               node_in   = (wrs_pkg::action_type'(req_tuser) == wrs_pkg::ACT_SET) ?
                           {1'b1, LEAF_W'(req_slot)} : ADDR_W'(1);
               path_in   = LEAF_W'(req_slot) + LEAF_W'(1);
               acc_in    = '0;
               target_in = CMP_W'(req_tdata[83:42]);
               new_w_in  = SUM_W'(WEIGHT_BITS'(req_tdata[41:10]));
               draw_in   = DRAW_BITS'(req_tdata[115:84]);
               mcnt_in   = '0;
               found_in  = 1'b0;
               chosen_in = '0;
               psum_in   = (wrs_pkg::action_type'(req_tuser) == wrs_pkg::ACT_PREFIX &&
                            !slot_ok) ? total_ff : '0;
            end
         end
         wrs_pkg::ST_MUL: begin
            acc_in  = alu_sum[SUM_W:1];
            draw_in = draw_ff >> 1;
            mcnt_in = mcnt_ff + MCNT_W'(1);
            if (mcnt_ff == MCNT_W'(DRAW_BITS - 1)) begin
               target_in = CMP_W'(alu_sum[SUM_W:1]);
               acc_in    = '0;
            end
         end
         wrs_pkg::ST_DN_STEP: begin
            node_in = node_step;
            path_in = path_ff << 1;
            if (go_right) acc_in = alu_sum[SUM_W-1:0];
            if (node_step[ADDR_W-1]) begin
               if (action_ff == wrs_pkg::ACT_PREFIX) begin
                  psum_in = go_right ? alu_sum[SUM_W-1:0] : acc_ff;
               end else begin
                  found_in  = 1'b1;
                  chosen_in = node_step[LEAF_W-1:0];
               end
            end
         end
         wrs_pkg::ST_LEAF_WR: begin
            delta_in = alu_sum[SUM_W-1:0];
            if (new_w_ff != '0 && rd_sum == '0) dcnt_in = CNT_W'(1);
            else if (new_w_ff == '0 && rd_sum != '0) dcnt_in = {CNT_W{1'b1}};
            else dcnt_in = '0;
            node_in = node_ff >> 1;
         end
         wrs_pkg::ST_UP_WR: begin
            node_in = node_ff >> 1;
            if (node_ff == ADDR_W'(1)) begin
               total_in = alu_sum[SUM_W-1:0];
               nz_in    = up_cnt;
            end
         end
         wrs_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_chosen_in = wrs_pkg::SLOT_W'(chosen_ff);
               rsp_psum_in   = wrs_pkg::SUM_OUT_W'(psum_ff);
               rsp_total_in  = wrs_pkg::SUM_OUT_W'(total_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      node_ff       <= node_in;
      path_ff       <= path_in;
      acc_ff        <= acc_in;
      target_ff     <= target_in;
      new_w_ff      <= new_w_in;
      delta_ff      <= delta_in;
      dcnt_ff       <= dcnt_in;
      draw_ff       <= draw_in;
      mcnt_ff       <= mcnt_in;
      found_ff      <= found_in;
      chosen_ff     <= chosen_in;
      psum_ff       <= psum_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_psum_ff   <= rsp_psum_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule
`default_nettype wire
